// ===== rtl/cnktl_pkg.sv =====
`default_nettype none

package cnktl_pkg;

	// defaults for the top-level parameters
	localparam int MAX_ROWS_DEF    = 256;
	localparam int NUM_COLUMNS_DEF = 11;
	localparam int VALUE_BITS_DEF  = 32;

	localparam int ALL_COLS = 11;
	localparam int COL_W    = 32;
	localparam int NUM_KEYS = 7;
	localparam int KW       = $clog2(NUM_KEYS);

	// action codes
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	// column of each key, in the order the keys are applied
	localparam int KEY_COL [NUM_KEYS] = '{0, 4, 1, 2, 3, 5, 6};

	typedef logic [ALL_COLS-1:0][COL_W-1:0] cols_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [COL_W-1:0] col_slope;
		logic [COL_W-1:0] col_conductivity;
		logic [COL_W-1:0] col_anisotropy;
		logic [COL_W-1:0] col_flow;
		logic [COL_W-1:0] col_temperature;
		logic [COL_W-1:0] col_duration;
		logic [COL_W-1:0] col_dispersion;
		logic [COL_W-1:0] col_length;
		logic [COL_W-1:0] col_width;
		logic [COL_W-1:0] col_hyd_width;
		logic [COL_W-1:0] col_velocity;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [COL_W-1:0] out_slope;
		logic [COL_W-1:0] out_conductivity;
		logic [COL_W-1:0] out_anisotropy;
		logic [COL_W-1:0] out_flow;
		logic [COL_W-1:0] out_temperature;
		logic [COL_W-1:0] out_duration;
		logic [COL_W-1:0] out_dispersion;
		logic [COL_W-1:0] out_length;
		logic [COL_W-1:0] out_width;
		logic [COL_W-1:0] out_hyd_width;
		logic [COL_W-1:0] out_velocity;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic          load;       // write one row at addr
		logic          latch;      // capture query keys
		logic          clear_best; // start of a key pass
		logic          scan;       // nearest-value search read
		logic          prune;      // survivor update read
		logic          first_key;  // every row counts as a survivor
		logic [KW-1:0] key_idx;
		logic          use_sel;    // read the selected row
		logic          emit_row;
		logic          emit_none;
	} ctl_cmd_t;

	function automatic cols_t item_cols(input in_item_t it);
		cols_t c;
		c[0]  = it.col_slope;
		c[1]  = it.col_conductivity;
		c[2]  = it.col_anisotropy;
		c[3]  = it.col_flow;
		c[4]  = it.col_temperature;
		c[5]  = it.col_duration;
		c[6]  = it.col_dispersion;
		c[7]  = it.col_length;
		c[8]  = it.col_width;
		c[9]  = it.col_hyd_width;
		c[10] = it.col_velocity;
		return c;
	endfunction

	function automatic out_item_t pack_result(input logic found, input cols_t c);
		out_item_t r;
		r.found            = found;
		r.out_slope        = c[0];
		r.out_conductivity = c[1];
		r.out_anisotropy   = c[2];
		r.out_flow         = c[3];
		r.out_temperature  = c[4];
		r.out_duration     = c[5];
		r.out_dispersion   = c[6];
		r.out_length       = c[7];
		r.out_width        = c[8];
		r.out_hyd_width    = c[9];
		r.out_velocity     = c[10];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cnktl_ram.sv =====
`default_nettype none

module cnktl_ram #(
	parameter int WIDTH = cnktl_pkg::VALUE_BITS_DEF,
	parameter int DEPTH = cnktl_pkg::MAX_ROWS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/cnktl_ctrl.sv =====
`default_nettype none

module cnktl_ctrl #(
	parameter int MAX_ROWS = cnktl_pkg::MAX_ROWS_DEF,
	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [1:0]          action,
	output logic                     busy,
	output cnktl_pkg::ctl_cmd_t      cmd,
	output logic [AW-1:0]            addr
);
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int KW = cnktl_pkg::KW;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_PRUNE = 7'b0000100,
		S_GAP   = 7'b0001000,
		S_FETCH = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_NONE  = 7'b1000000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] r_q, r_d;
	logic [KW-1:0] k_q, k_d;
	logic          last_row;

	assign busy     = (state_q != S_IDLE);
	assign last_row = ((CW'(r_q) + CW'(1)) == count_q);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		r_d     = r_q;
		k_d     = k_q;
		cmd     = '0;
		addr    = r_q;
		cmd.key_idx   = k_q;
		cmd.first_key = (k_q == '0);
		unique case (state_q)
			S_IDLE: begin
				addr = count_q[AW-1:0];
				if (start) begin
					unique case (action)
						cnktl_pkg::ACT_CLEAR: begin
							count_d = '0;
						end
						cnktl_pkg::ACT_LOAD: begin
							if (count_q < CW'(MAX_ROWS)) begin
								cmd.load = 1'b1;
								count_d  = count_q + CW'(1);
							end
						end
						cnktl_pkg::ACT_QUERY: begin
							cmd.latch = 1'b1;
							if (count_q == '0) begin
								state_d = S_NONE;
							end else begin
								r_d            = '0;
								k_d            = '0;
								cmd.clear_best = 1'b1;
								state_d        = S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (last_row) begin
					r_d     = '0;
					state_d = S_PRUNE;
				end else begin
					r_d = r_q + AW'(1);
				end
			end
			S_PRUNE: begin
				cmd.prune = 1'b1;
				if (last_row) begin
					r_d     = '0;
					state_d = S_GAP;
				end else begin
					r_d = r_q + AW'(1);
				end
			end
			S_GAP: begin
				// lets the last survivor write land before the next pass reads it
				if (k_q == KW'(cnktl_pkg::NUM_KEYS - 1)) begin
					state_d = S_FETCH;
				end else begin
					k_d            = k_q + KW'(1);
					cmd.clear_best = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_FETCH: begin
				cmd.use_sel = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit_row = 1'b1;
				state_d      = S_IDLE;
			end
			S_NONE: begin
				cmd.emit_none = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			r_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			r_q     <= r_d;
			k_q     <= k_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cnktl_dpath.sv =====
`default_nettype none

module cnktl_dpath #(
	parameter int MAX_ROWS    = cnktl_pkg::MAX_ROWS_DEF,
	parameter int NUM_COLUMNS = cnktl_pkg::NUM_COLUMNS_DEF,
	parameter int VALUE_BITS  = cnktl_pkg::VALUE_BITS_DEF,
	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cnktl_pkg::ctl_cmd_t cmd,
	input  wire logic [AW-1:0]       addr,
	input  wire cnktl_pkg::in_item_t item,
	output cnktl_pkg::out_item_t     result,
	output logic                     done
);
	localparam int SW       = (VALUE_BITS < cnktl_pkg::COL_W) ? VALUE_BITS : cnktl_pkg::COL_W;
	localparam int NUM_KEYS = cnktl_pkg::NUM_KEYS;
	localparam int ALL_COLS = cnktl_pkg::ALL_COLS;

	cnktl_pkg::cols_t     in_cols;
	cnktl_pkg::cols_t     out_cols;
	logic [SW-1:0]        col_rd [NUM_COLUMNS];
	logic [SW-1:0]        key_vals [NUM_KEYS];
	logic [SW-1:0]        keys_q [NUM_KEYS];
	logic [AW-1:0]        rd_addr;
	logic                 mask_rd;

	cnktl_pkg::ctl_cmd_t  cmd_s1;
	logic [AW-1:0]        addr_s1;

	logic                 have_q, sel_have_q, done_q;
	logic [SW-1:0]        best_dist_q, best_val_q;
	logic [AW-1:0]        sel_q;
	cnktl_pkg::out_item_t result_q;

	logic [SW-1:0]        cur_val, cur_key, delta;
	logic                 alive, keep, closer;

	assign in_cols = cnktl_pkg::item_cols(item);
	assign rd_addr = cmd.use_sel ? sel_q : addr;

	for (genvar c = 0; c < NUM_COLUMNS; c++) begin : g_col
		cnktl_ram #(.WIDTH(SW), .DEPTH(MAX_ROWS)) u_col (
			.clk   (clk),
			.we    (cmd.load),
			.waddr (addr),
			.wdata (in_cols[c][SW-1:0]),
			.raddr (rd_addr),
			.rdata (col_rd[c])
		);
	end

	// survivor flags; rewritten for every row by each prune pass
	cnktl_ram #(.WIDTH(1), .DEPTH(MAX_ROWS)) u_mask (
		.clk   (clk),
		.we    (cmd_s1.prune),
		.waddr (addr_s1),
		.wdata (keep),
		.raddr (addr),
		.rdata (mask_rd)
	);

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		assign key_vals[k] = col_rd[cnktl_pkg::KEY_COL[k]];
	end

	for (genvar c = 0; c < ALL_COLS; c++) begin : g_out
		if (c < NUM_COLUMNS) begin : g_used
			assign out_cols[c] = cnktl_pkg::COL_W'(col_rd[c]);
		end else begin : g_zero
			assign out_cols[c] = '0;
		end
	end

	// read data stage
	always_comb begin
		cur_val = key_vals[cmd_s1.key_idx];
		cur_key = keys_q[cmd_s1.key_idx];
		delta   = (cur_val >= cur_key) ? (cur_val - cur_key) : (cur_key - cur_val);
		alive   = cmd_s1.first_key | mask_rd;
		closer  = !have_q || (delta < best_dist_q);
		keep    = alive && (cur_val == best_val_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1     <= '0;
			have_q     <= 1'b0;
			sel_have_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			cmd_s1 <= cmd;
			done_q <= cmd.emit_row | cmd.emit_none;
			if (cmd.clear_best) begin
				have_q     <= 1'b0;
				sel_have_q <= 1'b0;
			end else begin
				if (cmd_s1.scan && alive) begin
					have_q <= 1'b1;
				end
				if (cmd_s1.prune && keep) begin
					sel_have_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		if (cmd.latch) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				keys_q[k] <= in_cols[cnktl_pkg::KEY_COL[k]][SW-1:0];
			end
		end
		if (cmd_s1.scan && alive && closer) begin
			best_dist_q <= delta;
			best_val_q  <= cur_val;
		end
		if (cmd_s1.prune && keep && !sel_have_q) begin
			sel_q <= addr_s1;
		end
		if (cmd.emit_row) begin
			result_q <= cnktl_pkg::pack_result(1'b1, out_cols);
		end else if (cmd.emit_none) begin
			result_q <= '0;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

// ===== rtl/cascaded_nearest_key_table_lookup.sv =====
// Load and clear items are taken while idle; busy stays low and no result is made.
// Query: each key runs a search scan and a prune scan of the stored rows and a gap
// state, then fetch and emit states; result strobe on done, and busy drops in that cycle.
// Rate is set by the single read port of the column memories, one row a cycle.
// Empty table: done with found 0 and zero data after the none state. Results cannot be stalled.
// Reset clears the row count and control; table memory contents are left as they are.
`default_nettype none

module cascaded_nearest_key_table_lookup #(
	parameter int MAX_ROWS    = cnktl_pkg::MAX_ROWS_DEF,
	parameter int NUM_COLUMNS = cnktl_pkg::NUM_COLUMNS_DEF,
	parameter int VALUE_BITS  = cnktl_pkg::VALUE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire cnktl_pkg::in_item_t item,
	output logic                     busy,
	output cnktl_pkg::out_item_t     result,
	output logic                     done
);
	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	// Each key costs a search scan (nearest value among survivors, earlier
	// row wins a tie) and a prune scan (keep rows holding exactly that value),
	// then a gap state so the last survivor write settles. The prune scan
	// also records the first survivor, which is read back for the result.
	cnktl_pkg::ctl_cmd_t cmd;
	logic [AW-1:0]       addr;

	cnktl_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.busy   (busy),
		.cmd    (cmd),
		.addr   (addr)
	);

	cnktl_dpath #(
		.MAX_ROWS    (MAX_ROWS),
		.NUM_COLUMNS (NUM_COLUMNS),
		.VALUE_BITS  (VALUE_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.addr   (addr),
		.item   (item),
		.result (result),
		.done   (done)
	);

endmodule

`default_nettype wire

// ===== rtl/cnktl_checker.sv =====
`default_nettype none

module cnktl_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire cnktl_pkg::in_item_t  item,
	input wire logic                 busy,
	input wire cnktl_pkg::out_item_t result,
	input wire logic                 done
);

	// a result only comes out once the query is finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done on back-to-back cycles");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == cnktl_pkg::ACT_QUERY) |=> busy)
		else $error("query did not start");

	a_table_op_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.action == cnktl_pkg::ACT_LOAD ||
			item.action == cnktl_pkg::ACT_CLEAR)) |=> (!busy && !done))
		else $error("load or clear did not finish in one cycle");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.out_slope == '0 &&
			result.out_temperature == '0 && result.out_velocity == '0 &&
			result.out_length == '0))
		else $error("empty result carries data");

endmodule

bind cascaded_nearest_key_table_lookup cnktl_checker u_cnktl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.item   (item),
	.busy   (busy),
	.result (result),
	.done   (done)
);

`default_nettype wire

// ===== verif/cascaded_nearest_key_table_lookup_tb.sv =====
`timescale 1ns / 100ps

module cascaded_nearest_key_table_lookup_tb;
	import cnktl_pkg::*;

	localparam int ROWS             = MAX_ROWS_DEF;
	localparam int RANDOM_ITEMS     = 160;
	// longest query: a search and a prune scan of every stored row for each key
	localparam int QUERY_MAX_CYCLES = 14 * ROWS + 9;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	// column searched by each key, in the order the keys are applied
	localparam logic [NUM_KEYS-1:0][3:0] KEY_ORDER = {4'd6, 4'd5, 4'd3, 4'd2, 4'd1, 4'd4, 4'd0};

	typedef logic [ALL_COLS-1:0][COL_W-1:0] row_vec_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	in_item_t  item   = '0;
	logic      busy;
	out_item_t result;
	logic      done;

	string col_tag [0:ALL_COLS-1] = '{"slope", "conductivity", "anisotropy", "flow",
		"temperature", "duration", "dispersion", "length", "width", "hyd_width", "velocity"};

	// table mirror, updated as items are accepted
	row_vec_t    mirror_rows [ROWS];
	int unsigned mirror_count = 0;
	out_item_t   pending_results [$];
	int          mismatches = 0;
	int          item_total = 0;  // accepted clear/load/query items
	int          burst_left = 0;

	cascaded_nearest_key_table_lookup dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.result (result),
		.done   (done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// column order of a row: the order of the input fields
	function automatic row_vec_t cols_of(input in_item_t it);
		row_vec_t r;
		r[0]  = it.col_slope;
		r[1]  = it.col_conductivity;
		r[2]  = it.col_anisotropy;
		r[3]  = it.col_flow;
		r[4]  = it.col_temperature;
		r[5]  = it.col_duration;
		r[6]  = it.col_dispersion;
		r[7]  = it.col_length;
		r[8]  = it.col_width;
		r[9]  = it.col_hyd_width;
		r[10] = it.col_velocity;
		return r;
	endfunction

	function automatic in_item_t item_of(input logic [1:0] act, input row_vec_t r);
		in_item_t it;
		it.action           = act;
		it.col_slope        = r[0];
		it.col_conductivity = r[1];
		it.col_anisotropy   = r[2];
		it.col_flow         = r[3];
		it.col_temperature  = r[4];
		it.col_duration     = r[5];
		it.col_dispersion   = r[6];
		it.col_length       = r[7];
		it.col_width        = r[8];
		it.col_hyd_width    = r[9];
		it.col_velocity     = r[10];
		return it;
	endfunction

	function automatic out_item_t result_of(input logic hit, input row_vec_t r);
		out_item_t o;
		o.found            = hit;
		o.out_slope        = r[0];
		o.out_conductivity = r[1];
		o.out_anisotropy   = r[2];
		o.out_flow         = r[3];
		o.out_temperature  = r[4];
		o.out_duration     = r[5];
		o.out_dispersion   = r[6];
		o.out_length       = r[7];
		o.out_width        = r[8];
		o.out_hyd_width    = r[9];
		o.out_velocity     = r[10];
		return o;
	endfunction

	function automatic row_vec_t row_of_result(input out_item_t o);
		row_vec_t r;
		r[0]  = o.out_slope;
		r[1]  = o.out_conductivity;
		r[2]  = o.out_anisotropy;
		r[3]  = o.out_flow;
		r[4]  = o.out_temperature;
		r[5]  = o.out_duration;
		r[6]  = o.out_dispersion;
		r[7]  = o.out_length;
		r[8]  = o.out_width;
		r[9]  = o.out_hyd_width;
		r[10] = o.out_velocity;
		return r;
	endfunction

	function automatic row_vec_t any_row();
		row_vec_t r;
		for (int c = 0; c < ALL_COLS; c++)
			r[c] = $urandom;
		return r;
	endfunction

	// Cascade: each key narrows the survivors to the rows holding the nearest
	// value of its column; strict < keeps the earlier row's value on a tie.
	function automatic out_item_t nearest_row_lookup(input in_item_t q);
		row_vec_t         keys;
		bit               alive [ROWS];
		logic [COL_W-1:0] best_val, best_dist, delta, v;
		bit               have;
		int               col;
		keys = cols_of(q);
		if (mirror_count == 0)
			return '0;
		for (int r = 0; r < mirror_count; r++)
			alive[r] = 1'b1;
		for (int k = 0; k < NUM_KEYS; k++) begin
			col       = KEY_ORDER[k];
			have      = 1'b0;
			best_val  = '0;
			best_dist = '0;
			for (int r = 0; r < mirror_count; r++) begin
				if (alive[r]) begin
					v     = mirror_rows[r][col];
					delta = (v >= keys[col]) ? v - keys[col] : keys[col] - v;
					if (!have || delta < best_dist) begin
						have      = 1'b1;
						best_dist = delta;
						best_val  = v;
					end
				end
			end
			for (int r = 0; r < mirror_count; r++)
				if (alive[r] && mirror_rows[r][col] != best_val)
					alive[r] = 1'b0;
		end
		for (int r = 0; r < mirror_count; r++)
			if (alive[r])
				return result_of(1'b1, mirror_rows[r]);
		return '0;
	endfunction

	function automatic void apply_item(input in_item_t it);
		case (it.action)
			ACT_CLEAR: begin
				mirror_count = 0;
			end
			ACT_LOAD: begin
				// full table: row dropped
				if (mirror_count < ROWS) begin
					mirror_rows[mirror_count] = cols_of(it);
					mirror_count++;
				end
			end
			ACT_QUERY: begin
				pending_results.insert(pending_results.size(), nearest_row_lookup(it));
			end
			default: ;
		endcase
	endfunction

	// Results cannot be held off: every strobe is compared with the oldest
	// query still waiting.
	always @(posedge clk) begin : result_check
		out_item_t want;
		row_vec_t  want_row, got_row;
		if (arst_n && done) begin
			got_row = row_of_result(result);
			if (pending_results.size() == 0) begin
				$display("%0t: result with no query waiting: expected none, actual found=%0b row=%h",
					$time, result.found, got_row);
				mismatches++;
			end else begin
				want     = pending_results.pop_front();
				want_row = row_of_result(want);
				if (result.found !== want.found) begin
					$display("%0t: found expected %0b actual %0b", $time, want.found, result.found);
					mismatches++;
				end
				for (int c = 0; c < ALL_COLS; c++)
					if (got_row[c] !== want_row[c]) begin
						$display("%0t: %s expected %h actual %h",
							$time, col_tag[c], want_row[c], got_row[c]);
						mismatches++;
					end
			end
		end
	end

	// Called at a rising edge. start stays high from one item to the next
	// within a burst; a gap of random length follows each burst.
	task automatic issue_item(input in_item_t it);
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_item(it);
		if (it.action != ACT_UNUSED)
			item_total++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
		end
	endtask

	// hold off the sender until every query has answered
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic test_empty_table();
		issue_item(item_of(ACT_QUERY, '0));
		issue_item(item_of(ACT_QUERY, '1));
		issue_item(item_of(ACT_CLEAR, any_row()));
		issue_item(item_of(ACT_QUERY, any_row()));
	endtask

	task automatic test_extreme_values();
		row_vec_t r;
		issue_item(item_of(ACT_LOAD, '0));
		issue_item(item_of(ACT_LOAD, '1));
		for (int c = 0; c < ALL_COLS; c++)
			r[c] = c[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
		issue_item(item_of(ACT_LOAD, r));
		issue_item(item_of(ACT_QUERY, '0));
		issue_item(item_of(ACT_QUERY, '1));
		issue_item(item_of(ACT_QUERY, {ALL_COLS{32'h8000_0000}}));
	endtask

	// slope ties between 10 and 20, then temperature decides or ties again
	task automatic test_equal_distance();
		row_vec_t r;
		issue_item(item_of(ACT_CLEAR, '0));
		r = '0; r[0] = 20; r[4] = 50;  r[7] = 1;
		issue_item(item_of(ACT_LOAD, r));
		r = '0; r[0] = 10; r[4] = 90;  r[7] = 2;
		issue_item(item_of(ACT_LOAD, r));
		r = '0; r[0] = 20; r[4] = 100; r[7] = 3;
		issue_item(item_of(ACT_LOAD, r));
		r = '0; r[0] = 15; r[4] = 90;
		issue_item(item_of(ACT_QUERY, r));
		r = '0; r[0] = 15; r[4] = 75;
		issue_item(item_of(ACT_QUERY, r));
		r = '0; r[0] = 11; r[4] = 75; r[8] = '1;
		issue_item(item_of(ACT_QUERY, r));
	endtask

	// code 3 looks like a load here but must leave the table alone
	task automatic test_unused_code();
		row_vec_t r;
		r = '0; r[0] = 16; r[4] = 75; r[7] = 32'hDEAD_0003;
		issue_item(item_of(ACT_UNUSED, r));
		issue_item(item_of(ACT_QUERY, r));
	endtask

	task automatic test_clear_table();
		issue_item(item_of(ACT_CLEAR, any_row()));
		issue_item(item_of(ACT_QUERY, '0));
	endtask

	// fill past capacity; the dropped rows hold a slope no stored row is near
	task automatic test_table_full();
		row_vec_t r;
		issue_item(item_of(ACT_CLEAR, '0));
		for (int i = 0; i < ROWS + 2; i++) begin
			r     = '0;
			r[0]  = (i < ROWS) ? i * 8 : 32'hFFFF_FFF0;
			r[7]  = i;
			r[8]  = ~i;
			r[9]  = i << 16;
			r[10] = $urandom;
			issue_item(item_of(ACT_LOAD, r));
		end
		drain_results();
		r = '0; r[0] = 32'hFFFF_FFFF;
		issue_item(item_of(ACT_QUERY, r));
		r = '0;
		issue_item(item_of(ACT_QUERY, r));
		r = '0; r[0] = 1004;
		issue_item(item_of(ACT_QUERY, r));
		drain_results();
	endtask

	// Mostly well-formed sequences: clear, a few rows drawn from small value
	// sets (so columns repeat and distances tie), then queries near those
	// values. The rest is noise: random codes and queries on an empty table.
	task automatic test_random_lookups();
		row_vec_t base, step, row, keys;
		int       n_load, n_query, target, pick;
		target = item_total + RANDOM_ITEMS;
		while (item_total < target) begin
			if ($urandom_range(0, 9) == 0)
				drain_results();
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				repeat ($urandom_range(1, 3))
					issue_item(item_of(2'($urandom_range(0, 3)), any_row()));
			end else if (pick == 1) begin
				issue_item(item_of(ACT_CLEAR, any_row()));
				issue_item(item_of(ACT_QUERY, any_row()));
			end else begin
				if (mirror_count > 40 || $urandom_range(0, 3) != 0)
					issue_item(item_of(ACT_CLEAR, any_row()));
				for (int c = 0; c < ALL_COLS; c++) begin
					case ($urandom_range(0, 3))
						0:       base[c] = $urandom_range(0, 20);
						1:       base[c] = 32'hFFFF_FFFF - $urandom_range(0, 40);
						default: base[c] = $urandom;
					endcase
					step[c] = 2 * $urandom_range(1, 3);
				end
				n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
				for (int i = 0; i < n_load; i++) begin
					if (i == 0 || $urandom_range(0, 9) != 0)
						for (int c = 0; c < ALL_COLS; c++)
							row[c] = ($urandom_range(0, 4) != 0) ?
								base[c] + step[c] * $urandom_range(0, 3) : $urandom;
					issue_item(item_of(ACT_LOAD, row));
				end
				n_query = $urandom_range(1, 5);
				for (int i = 0; i < n_query; i++) begin
					keys = any_row();
					for (int c = 0; c < NUM_KEYS; c++) begin
						pick = $urandom_range(0, 19);
						if (pick < 13)
							keys[c] = base[c] - step[c] + $urandom_range(0, 5 * step[c]);
						else if (pick < 16 && mirror_count > 0)
							keys[c] = mirror_rows[$urandom_range(0, mirror_count - 1)][c];
					end
					issue_item(item_of(ACT_QUERY, keys));
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_extreme_values();
		test_equal_distance();
		test_unused_code();
		test_clear_table();
		test_table_full();
		test_random_lookups();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// long enough for a stray result from a full-table query to show up
		repeat (QUERY_MAX_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog: many times the slowest legal run
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
